/* rtl/core/adsl_pkg.sv */
// Shared types, constants and helpers for the accel/decel slew limiter.
// No dependencies; imported by every module of the block.
`default_nettype none

package adsl_pkg;

    localparam int SPEED_W = 15;
    localparam int RATE_W  = 14;
    localparam int MS_W    = 7;
    localparam int ELAP_W  = 16;
    localparam int PROD_W  = RATE_W + MS_W;
    localparam int STEP_W  = 18;
    localparam int ADDR_W  = 4;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX     = 15'sd10000;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN     = -15'sd10000;
    localparam logic        [SPEED_W-2:0] NEAR_ZERO_REV = 14'd500;
    localparam logic        [ELAP_W-1:0]  LONG_STEP_MS  = 16'd100;

    localparam logic [RATE_W-1:0] ACCEL_RESET = 14'd800;
    localparam logic [RATE_W-1:0] DECEL_RESET = 14'd1200;
    localparam logic [MS_W-1:0]   STEP_RESET  = 7'd20;

    // floor(x/10) == (x * DIV10_MUL) >> DIV10_SHIFT for x < 2^22
    localparam int              DIV10_SHIFT = 23;
    localparam logic [19:0]     DIV10_MUL   = 20'd838861;
    localparam int              QFULL_W     = PROD_W + 20;

    typedef enum logic [1:0] {
        REG_ACCEL = 2'd0,
        REG_DECEL = 2'd1,
        REG_STEP  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic en1;
        logic en2;
    } ctrl_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] tl;
        logic signed [SPEED_W-1:0] tr;
        logic                      hold;
        logic [STEP_W-1:0]         step_a;
        logic [STEP_W-1:0]         step_d;
    } step_word_t;

    function automatic logic signed [SPEED_W-1:0] clamp_speed(
        input logic signed [SPEED_W-1:0] v
    );
        logic signed [SPEED_W-1:0] r;
        begin
            if (v > SPEED_MAX) begin
                r = SPEED_MAX;
            end else if (v < SPEED_MIN) begin
                r = SPEED_MIN;
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/adsl_step_gen.sv */
// Shared step generator: clamps targets, forms rate*ms products, divides by 10.
// Two register stages; depends on adsl_pkg.
`default_nettype none

module adsl_step_gen import adsl_pkg::*; (
    input  wire logic                      aclk,
    input  wire ctrl_t                     ctrl,
    input  wire logic signed [SPEED_W-1:0] target_left,
    input  wire logic signed [SPEED_W-1:0] target_right,
    input  wire logic [ELAP_W-1:0]         elapsed_ms,
    input  wire logic [RATE_W-1:0]         accel_rate,
    input  wire logic [RATE_W-1:0]         decel_rate,
    input  wire logic [MS_W-1:0]           default_ms,
    output step_word_t                     stg_out
);

    logic signed [SPEED_W-1:0] tl1_reg, tr1_reg;
    logic                      hold1_reg;
    logic [PROD_W-1:0]         prod_a1_reg, prod_d1_reg;
    logic [MS_W-1:0]           ms_eff;
    logic [PROD_W-1:0]         prod_a_next, prod_d_next;
    logic [QFULL_W-1:0]        qa_full, qd_full;
    step_word_t                stg_reg, stg_next;

    always_comb begin
        ms_eff = (elapsed_ms > LONG_STEP_MS) ? default_ms : elapsed_ms[MS_W-1:0];
        prod_a_next = {{MS_W{1'b0}}, accel_rate} * {{RATE_W{1'b0}}, ms_eff};
        prod_d_next = {{MS_W{1'b0}}, decel_rate} * {{RATE_W{1'b0}}, ms_eff};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en1) begin
            tl1_reg     <= clamp_speed(target_left);
            tr1_reg     <= clamp_speed(target_right);
            hold1_reg   <= (elapsed_ms == '0);
            prod_a1_reg <= prod_a_next;
            prod_d1_reg <= prod_d_next;
        end
    end

    always_comb begin
        qa_full = {20'b0, prod_a1_reg} * {{PROD_W{1'b0}}, DIV10_MUL};
        qd_full = {20'b0, prod_d1_reg} * {{PROD_W{1'b0}}, DIV10_MUL};
        stg_next.tl     = tl1_reg;
        stg_next.tr     = tr1_reg;
        stg_next.hold   = hold1_reg;
        stg_next.step_a = qa_full[DIV10_SHIFT +: STEP_W];
        stg_next.step_d = qd_full[DIV10_SHIFT +: STEP_W];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en2) begin
            stg_reg <= stg_next;
        end
    end

    assign stg_out = stg_reg;

endmodule

`default_nettype wire

/* rtl/core/adsl_lane.sv */
// One side of the limiter: picks accel or decel step and moves last toward target.
// Combinational; depends on adsl_pkg.
`default_nettype none

module adsl_lane import adsl_pkg::*; (
    input  wire logic signed [SPEED_W-1:0] target,
    input  wire logic signed [SPEED_W-1:0] last,
    input  wire logic                      hold,
    input  wire logic [STEP_W-1:0]         step_a,
    input  wire logic [STEP_W-1:0]         step_d,
    output logic signed [SPEED_W-1:0]      next
);

    logic signed [SPEED_W:0]   delta;
    logic [SPEED_W-1:0]        mag_d;
    logic [SPEED_W-2:0]        mag_t, mag_l;
    logic                      accel;
    logic [STEP_W-1:0]         step;
    logic                      move;

    always_comb begin
        delta = {target[SPEED_W-1], target} - {last[SPEED_W-1], last};
        mag_d = delta[SPEED_W] ? SPEED_W'(-delta) : delta[SPEED_W-1:0];
        mag_t = target[SPEED_W-1] ? (SPEED_W-1)'(-target) : target[SPEED_W-2:0];
        mag_l = last[SPEED_W-1] ? (SPEED_W-1)'(-last) : last[SPEED_W-2:0];

        if (last == '0) begin
            accel = 1'b1;
        end else if (target == '0) begin
            accel = 1'b0;
        end else if ((last > 0) == (target > 0)) begin
            accel = (mag_t > mag_l);
        end else begin
            accel = (mag_l < NEAR_ZERO_REV);
        end

        step = accel ? step_a : step_d;
        move = ({{(STEP_W-SPEED_W){1'b0}}, mag_d} > step);

        if (hold) begin
            next = last;
        end else if (!move) begin
            next = target;
        end else if (!delta[SPEED_W]) begin
            next = last + $signed(step[SPEED_W-1:0]);
        end else begin
            next = last - $signed(step[SPEED_W-1:0]);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/accel_decel_slew_limiter.sv */
// Asymmetric slew limiter for two motor sides, APB config, valid/ready words.
// Each stage below is registered; one word per cycle sustained while m_ready is high.
// Stages: clamp and rate*ms multiply, divide by 10, then both lanes merge into the
// output register, which also holds the last speeds (the only feedback path).
// Synchronous active-low reset: speeds to 0, rates to 800/1200, default step 20 ms.
// Uses adsl_pkg, adsl_step_gen, adsl_lane.
`default_nettype none

module accel_decel_slew_limiter import adsl_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ADDR_W-1:0]         paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [SPEED_W-1:0] s_target_left,
    input  wire logic signed [SPEED_W-1:0] s_target_right,
    input  wire logic [ELAP_W-1:0]         s_elapsed_ms,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [SPEED_W-1:0]      m_limited_left,
    output logic signed [SPEED_W-1:0]      m_limited_right
);

    logic [RATE_W-1:0]         accel_reg, decel_reg;
    logic [MS_W-1:0]           dstep_reg;
    logic                      v1_reg, v2_reg, mv_reg;
    logic signed [SPEED_W-1:0] last_l_reg, last_r_reg;
    logic signed [SPEED_W-1:0] last_l_next, last_r_next;
    logic                      out_adv, adv2, adv1, wr_en;
    ctrl_t                     ctrl;
    step_word_t                stg;
    reg_idx_t                  widx;

    // config port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign widx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_reg <= ACCEL_RESET;
            decel_reg <= DECEL_RESET;
            dstep_reg <= STEP_RESET;
        end else if (wr_en) begin
            unique case (widx)
                REG_ACCEL: accel_reg <= pwdata[RATE_W-1:0];
                REG_DECEL: decel_reg <= pwdata[RATE_W-1:0];
                REG_STEP:  dstep_reg <= pwdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_ACCEL: prdata = {{(32-RATE_W){1'b0}}, accel_reg};
            REG_DECEL: prdata = {{(32-RATE_W){1'b0}}, decel_reg};
            REG_STEP:  prdata = {{(32-MS_W){1'b0}}, dstep_reg};
            default:   prdata = '0;
        endcase
    end

    // pipeline control
    assign out_adv  = !mv_reg || m_ready;
    assign adv2     = !v2_reg || out_adv;
    assign adv1     = !v1_reg || adv2;
    assign s_ready  = adv1;
    assign ctrl.en1 = adv1;
    assign ctrl.en2 = adv2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (out_adv) begin
                mv_reg <= v2_reg;
            end
        end
    end

    adsl_step_gen u_step_gen (
        .aclk         (aclk),
        .ctrl         (ctrl),
        .target_left  (s_target_left),
        .target_right (s_target_right),
        .elapsed_ms   (s_elapsed_ms),
        .accel_rate   (accel_reg),
        .decel_rate   (decel_reg),
        .default_ms   (dstep_reg),
        .stg_out      (stg)
    );

    adsl_lane u_lane_left (
        .target (stg.tl),
        .last   (last_l_reg),
        .hold   (stg.hold),
        .step_a (stg.step_a),
        .step_d (stg.step_d),
        .next   (last_l_next)
    );

    adsl_lane u_lane_right (
        .target (stg.tr),
        .last   (last_r_reg),
        .hold   (stg.hold),
        .step_a (stg.step_a),
        .step_d (stg.step_d),
        .next   (last_r_next)
    );

    // merge: both lanes commit together into the output/state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_l_reg <= '0;
            last_r_reg <= '0;
        end else if (out_adv && v2_reg) begin
            last_l_reg <= last_l_next;
            last_r_reg <= last_r_next;
        end
    end

    assign m_valid         = mv_reg;
    assign m_limited_left  = last_l_reg;
    assign m_limited_right = last_r_reg;

    a_last_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(out_adv && v2_reg) |=> $stable(last_l_reg) && $stable(last_r_reg))
        else $error("last speed changed without a committed word");

    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> (last_l_reg <= SPEED_MAX) && (last_l_reg >= SPEED_MIN))
        else $error("left speed out of range");

    a_right_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> (last_r_reg <= SPEED_MAX) && (last_r_reg >= SPEED_MIN))
        else $error("right speed out of range");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !out_adv |=> v2_reg && mv_reg)
        else $error("stalled word lost in pipeline");

endmodule

`default_nettype wire
